// File: hdl/pp_pkg.sv
// Shared types and constants for the 1D particle push block.
package pp_pkg;

	localparam int GRID_POINTS_DEF = 1024;

	localparam logic [31:0] ACCEL_RST       = 32'd0;
	localparam logic [30:0] TIME_STEP_RST   = 31'd65536;
	localparam logic [30:0] INV_CELL_RST    = 31'd65536;
	localparam logic [30:0] DOMAIN_LEN_RST  = 31'd65536;
	localparam logic [30:0] ENERGY_SCL_RST  = 31'd32768;
	localparam logic [30:0] FLUX_SCL_RST    = 31'd65536;
	localparam logic [30:0] EFLUX_SCL_RST   = 31'd65536;

	localparam logic [30:0] MAX31 = '1;
	localparam logic [46:0] MAX47 = '1;
	localparam logic [47:0] MAX48 = '1;

	localparam logic KIND_PARTICLE = 1'b0;
	localparam logic KIND_REPORT   = 1'b1;

	localparam logic ACC_FLUX  = 1'b0;
	localparam logic ACC_EFLUX = 1'b1;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_PUSH   = 2'd1,
		FUNC_REPORT = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		REG_ACCEL       = 3'd0,
		REG_TIME_STEP   = 3'd1,
		REG_INV_CELL    = 3'd2,
		REG_DOMAIN_LEN  = 3'd3,
		REG_ENERGY_SCL  = 3'd4,
		REG_FLUX_SCL    = 3'd5,
		REG_EFLUX_SCL   = 3'd6
	} reg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// File: hdl/pp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hdl/pp_isqrt.sv
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
module pp_isqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [63:0]        radicand,
	output pp_pkg::unit_stat_t stat,
	output logic [31:0]        root
);
	import pp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [63:0] data_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        fit;

	assign rem_sh = {rem_q, data_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign fit    = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			data_q <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			data_q <= {data_q[61:0], 2'b00};
			rem_q  <= fit ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], fit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = root_q;

endmodule

// File: hdl/pp_div.sv
// Restoring divider giving the 17-bit quotient (|vz| << 16) / speed, one bit per cycle.
module pp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [31:0]        avz,
	input  logic [31:0]        divisor,
	output pp_pkg::unit_stat_t stat,
	output logic [16:0]        quo
);
	import pp_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] div_q;
	logic [16:0] feed_q;
	logic [16:0] quo_q;
	logic [32:0] rem_sh;
	logic        fit;

	assign rem_sh = {rem_q, feed_q[16]};
	assign fit    = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, avz[31:1]};
			feed_q <= {avz[0], 16'd0};
			div_q  <= divisor;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= fit ? 32'(rem_sh - {1'b0, div_q}) : rem_sh[31:0];
			feed_q <= {feed_q[15:0], 1'b0};
			quo_q  <= {quo_q[15:0], fit};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

// File: hdl/pic_1d_particle_push.sv
// Top level of the 1D particle push: field store, wall accumulators and push sequencer.
// A field load is written when it is accepted. A surviving particle raises its result beat
// once the output register is free, and the next item is taken after the beat is loaded.
// An absorbed particle passes through the 32-step square root and, for a nonzero speed,
// the 17-step divider; a flux report runs through the shared multiplier.
// One item is worked at a time. Reset clears control state, registers and wall accumulators;
// the field store has no reset value and must be loaded before particles are pushed.
module pic_1d_particle_push #(
	parameter int GRID_POINTS = pp_pkg::GRID_POINTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  func,
	input  logic [9:0]  field_index,
	input  logic [31:0] field_value,
	input  logic [30:0] pos,
	input  logic [31:0] vel_x,
	input  logic [31:0] vel_y,
	input  logic [31:0] vel_z,
	input  logic [30:0] weight,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        kind,
	output logic [30:0] pos_new,
	output logic [31:0] vel_x_out,
	output logic [31:0] vel_y_out,
	output logic [31:0] vel_z_new,
	output logic [30:0] energy,
	output logic [30:0] weight_out,
	output logic [46:0] flux_low,
	output logic [46:0] flux_high,
	output logic [46:0] eflux_low,
	output logic [46:0] eflux_high
);
	import pp_pkg::*;

	localparam int AW = $clog2(GRID_POINTS);
	localparam logic [45:0] CELL_MAX = 46'(GRID_POINTS - 1) << 16;
	localparam logic [AW-1:0] IP_MAX = AW'(GRID_POINTS - 2);

	typedef enum logic [30:0] {
		S_IDLE     = 31'h00000001,
		S_CELL_MUL = 31'h00000002,
		S_CELL     = 31'h00000004,
		S_RD0      = 31'h00000008,
		S_RD1      = 31'h00000010,
		S_EZ       = 31'h00000020,
		S_AS_MUL   = 31'h00000040,
		S_VZ       = 31'h00000080,
		S_TS       = 31'h00000100,
		S_Z        = 31'h00000200,
		S_V1       = 31'h00000400,
		S_V2       = 31'h00000800,
		S_V3       = 31'h00001000,
		S_E0       = 31'h00002000,
		S_E1       = 31'h00004000,
		S_EN       = 31'h00008000,
		S_SQRT     = 31'h00010000,
		S_DIV      = 31'h00020000,
		S_WC       = 31'h00040000,
		S_WE       = 31'h00080000,
		S_WE2      = 31'h00100000,
		S_WE3      = 31'h00200000,
		S_WE4      = 31'h00400000,
		S_EADD     = 31'h00800000,
		S_ACC_F    = 31'h01000000,
		S_ACC_E    = 31'h02000000,
		S_R_RD     = 31'h04000000,
		S_R_MLO    = 31'h08000000,
		S_R_MHI    = 31'h10000000,
		S_R_ACC    = 31'h20000000,
		S_OUT_C    = 31'h40000000
	} state_t;

	state_t state_q;
	logic   rep_mode_q;
	logic   item_acc;

	logic [31:0] accel_q;
	logic [30:0] ts_q;
	logic [30:0] ics_q;
	logic [30:0] dl_q;
	logic [30:0] es_q;
	logic [30:0] fs_q;
	logic [30:0] efs_q;

	logic [30:0] pos_q;
	logic [31:0] vx_q;
	logic [31:0] vy_q;
	logic [31:0] vz_q;
	logic [30:0] w_q;

	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] prod_q;

	logic [45:0]    cell_c;
	logic [45:0]    cellc_c;
	logic [AW-1:0]  ipw_c;
	logic [AW-1:0]  ip_c;
	logic [16:0]    frac_c;
	logic [AW-1:0]  ip_q;
	logic [16:0]    frac_q;
	logic signed [65:0] sum_q;
	logic signed [65:0] ez_sum;
	logic [31:0]    ez_q;
	logic [48:0]    vz_sum;
	logic [31:0]    vzn_c;
	logic [31:0]    vzn_q;
	logic signed [48:0] z_q;
	logic [63:0]    v2_q;
	logic [30:0]    elo_q;
	logic [63:0]    e_sum;
	logic [30:0]    energy_q;
	logic           inside_c;
	logic           wall_hi;
	logic [31:0]    avz_c;
	logic [16:0]    cos_q;
	logic [31:0]    fadd_q;
	logic [45:0]    we_q;
	logic [48:0]    lo_q;
	logic [47:0]    eadd_q;

	logic [1:0]     k_q;
	logic [23:0]    acc_hi_q;
	logic [54:0]    lop_q;
	logic [30:0]    rscale;
	logic [63:0]    rep_sum;
	logic [46:0]    rep_q [4];

	logic           fld_we;
	logic [AW-1:0]  fld_waddr;
	logic [AW-1:0]  fld_raddr;
	logic [31:0]    fld_rdata;

	logic           acc_we;
	logic [1:0]     acc_waddr;
	logic [47:0]    acc_wdata;
	logic [1:0]     acc_raddr;
	logic [47:0]    acc_rdata;
	logic [3:0]     acc_vld_q;
	logic           acc_rv_q;
	logic [47:0]    accv;
	logic [48:0]    acc_sum;

	pp_pkg::unit_stat_t sq_stat;
	pp_pkg::unit_stat_t dv_stat;
	logic           sq_start;
	logic [31:0]    sq_root;
	logic           dv_start;
	logic [16:0]    dv_quo;

	logic           res_load;
	logic           res_valid_q;
	logic           kind_q;
	logic [30:0]    pos_new_q;
	logic [31:0]    vx_out_q;
	logic [31:0]    vy_out_q;
	logic [31:0]    vzn_out_q;
	logic [30:0]    energy_out_q;
	logic [30:0]    w_out_q;
	logic [46:0]    fl_q;
	logic [46:0]    fh_q;
	logic [46:0]    efl_q;
	logic [46:0]    efh_q;

	assign cfg_ready  = 1'b1;
	assign item_ready = (state_q == S_IDLE);
	assign item_acc   = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q <= ACCEL_RST;
			ts_q    <= TIME_STEP_RST;
			ics_q   <= INV_CELL_RST;
			dl_q    <= DOMAIN_LEN_RST;
			es_q    <= ENERGY_SCL_RST;
			fs_q    <= FLUX_SCL_RST;
			efs_q   <= EFLUX_SCL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ACCEL:      accel_q <= cfg_data;
				REG_TIME_STEP:  ts_q    <= cfg_data[30:0];
				REG_INV_CELL:   ics_q   <= cfg_data[30:0];
				REG_DOMAIN_LEN: dl_q    <= cfg_data[30:0];
				REG_ENERGY_SCL: es_q    <= cfg_data[30:0];
				REG_FLUX_SCL:   fs_q    <= cfg_data[30:0];
				REG_EFLUX_SCL:  efs_q   <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	// Cell coordinate, grid index and interpolation weight from the position product.
	assign cell_c  = prod_q[61:16];
	assign cellc_c = (cell_c > CELL_MAX) ? CELL_MAX : cell_c;
	assign ipw_c   = cellc_c[AW+15:16];
	assign ip_c    = (ipw_c > IP_MAX) ? IP_MAX : ipw_c;
	assign frac_c  = 17'(cellc_c[AW+15:0] - {ip_c, 16'd0});

	assign ez_sum = sum_q + prod_q;
	assign vz_sum = {{17{vz_q[31]}}, vz_q} + {prod_q[63], prod_q[63:16]};
	assign vzn_c  = (vz_sum[48:31] == '0 || vz_sum[48:31] == '1) ? vz_sum[31:0] :
		(vz_sum[48] ? 32'h80000000 : 32'h7FFFFFFF);
	assign e_sum    = prod_q[63:0] + {33'd0, elo_q};
	assign inside_c = (z_q > 49'sd0) && (z_q < $signed({18'd0, dl_q}));
	assign wall_hi  = (z_q > 49'sd0);
	assign avz_c    = vzn_q[31] ? (~vzn_q + 32'd1) : vzn_q;
	assign rscale   = k_q[1] ? efs_q : fs_q;
	assign rep_sum  = {1'b0, prod_q[54:0], 8'd0} + {25'd0, lop_q[54:16]};
	assign accv     = acc_rv_q ? acc_rdata : '0;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_CELL_MUL: begin
				mul_a = {2'b00, pos_q};
				mul_b = {2'b00, ics_q};
			end
			S_RD0: begin
				mul_a = {fld_rdata[31], fld_rdata};
				mul_b = {16'd0, 17'(17'h10000 - frac_q)};
			end
			S_RD1: begin
				mul_a = {fld_rdata[31], fld_rdata};
				mul_b = {16'd0, frac_q};
			end
			S_AS_MUL: begin
				mul_a = {accel_q[31], accel_q};
				mul_b = {ez_q[31], ez_q};
			end
			S_TS: begin
				mul_a = {vzn_q[31], vzn_q};
				mul_b = {2'b00, ts_q};
			end
			S_Z: begin
				mul_a = {vx_q[31], vx_q};
				mul_b = {vx_q[31], vx_q};
			end
			S_V1: begin
				mul_a = {vy_q[31], vy_q};
				mul_b = {vy_q[31], vy_q};
			end
			S_V2: begin
				mul_a = {vzn_q[31], vzn_q};
				mul_b = {vzn_q[31], vzn_q};
			end
			S_E0: begin
				mul_a = {2'b00, es_q};
				mul_b = {1'b0, v2_q[31:0]};
			end
			S_E1: begin
				mul_a = {2'b00, es_q};
				mul_b = {1'b0, v2_q[63:32]};
			end
			S_WC: begin
				mul_a = {2'b00, w_q};
				mul_b = {16'd0, cos_q};
			end
			S_WE: begin
				mul_a = {2'b00, w_q};
				mul_b = {2'b00, energy_q};
			end
			S_WE3: begin
				mul_a = {1'b0, we_q[31:0]};
				mul_b = {16'd0, cos_q};
			end
			S_WE4: begin
				mul_a = {19'd0, we_q[45:32]};
				mul_b = {16'd0, cos_q};
			end
			S_R_MLO: begin
				mul_a = {9'd0, accv[23:0]};
				mul_b = {2'b00, rscale};
			end
			S_R_MHI: begin
				mul_a = {9'd0, acc_hi_q};
				mul_b = {2'b00, rscale};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	assign fld_we    = item_acc && (func == FUNC_LOAD) &&
		(32'(field_index) < 32'(GRID_POINTS));
	assign fld_waddr = AW'(field_index);
	assign fld_raddr = (state_q == S_CELL) ? ip_c : (ip_q + AW'(1));

	pp_ram #(
		.WIDTH(32),
		.DEPTH(GRID_POINTS)
	) u_field_ram (
		.clk   (clk),
		.we    (fld_we),
		.waddr (fld_waddr),
		.wdata (field_value),
		.raddr (fld_raddr),
		.rdata (fld_rdata)
	);

	always_comb begin
		acc_raddr = k_q;
		acc_we    = 1'b0;
		acc_waddr = {ACC_FLUX, wall_hi};
		acc_wdata = '0;
		acc_sum   = '0;
		case (state_q)
			S_EADD: begin
				acc_raddr = {ACC_FLUX, wall_hi};
			end
			S_ACC_F: begin
				acc_raddr = {ACC_EFLUX, wall_hi};
				acc_sum   = {1'b0, accv} + {17'd0, fadd_q};
				acc_we    = 1'b1;
				acc_waddr = {ACC_FLUX, wall_hi};
				acc_wdata = acc_sum[48] ? MAX48 : acc_sum[47:0];
			end
			S_ACC_E: begin
				acc_sum   = {1'b0, accv} + {1'b0, eadd_q};
				acc_we    = 1'b1;
				acc_waddr = {ACC_EFLUX, wall_hi};
				acc_wdata = acc_sum[48] ? MAX48 : acc_sum[47:0];
			end
			S_R_ACC: begin
				acc_raddr = k_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	pp_ram #(
		.WIDTH(48),
		.DEPTH(4)
	) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (acc_raddr),
		.rdata (acc_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_vld_q <= '0;
			acc_rv_q  <= 1'b0;
		end else begin
			acc_rv_q <= acc_vld_q[acc_raddr];
			if ((state_q == S_R_ACC) && (k_q == 2'd3)) begin
				acc_vld_q <= '0;
			end else if (acc_we) begin
				acc_vld_q[acc_waddr] <= 1'b1;
			end
		end
	end

	assign sq_start = (state_q == S_EN) && !inside_c;
	assign dv_start = (state_q == S_SQRT) && sq_stat.done && (sq_root != '0);

	pp_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (v2_q),
		.stat     (sq_stat),
		.root     (sq_root)
	);

	pp_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (dv_start),
		.avz     (avz_c),
		.divisor (sq_root),
		.stat    (dv_stat),
		.quo     (dv_quo)
	);

	assign res_load = (state_q == S_OUT_C) && (!res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_acc) begin
						case (func)
							FUNC_PUSH:   state_q <= S_CELL_MUL;
							FUNC_REPORT: begin
								state_q <= S_R_RD;
								k_q     <= '0;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CELL_MUL: state_q <= S_CELL;
				S_CELL:     state_q <= S_RD0;
				S_RD0:      state_q <= S_RD1;
				S_RD1:      state_q <= S_EZ;
				S_EZ:       state_q <= S_AS_MUL;
				S_AS_MUL:   state_q <= S_VZ;
				S_VZ:       state_q <= S_TS;
				S_TS:       state_q <= S_Z;
				S_Z:        state_q <= S_V1;
				S_V1:       state_q <= S_V2;
				S_V2:       state_q <= S_V3;
				S_V3:       state_q <= S_E0;
				S_E0:       state_q <= S_E1;
				S_E1:       state_q <= S_EN;
				S_EN:       state_q <= inside_c ? S_OUT_C : S_SQRT;
				S_SQRT: begin
					if (sq_stat.done) begin
						state_q <= (sq_root == '0) ? S_WC : S_DIV;
					end
				end
				S_DIV: begin
					if (dv_stat.done) begin
						state_q <= S_WC;
					end
				end
				S_WC:       state_q <= S_WE;
				S_WE:       state_q <= S_WE2;
				S_WE2:      state_q <= S_WE3;
				S_WE3:      state_q <= S_WE4;
				S_WE4:      state_q <= S_EADD;
				S_EADD:     state_q <= S_ACC_F;
				S_ACC_F:    state_q <= S_ACC_E;
				S_ACC_E:    state_q <= S_IDLE;
				S_R_RD:     state_q <= S_R_MLO;
				S_R_MLO:    state_q <= S_R_MHI;
				S_R_MHI:    state_q <= S_R_ACC;
				S_R_ACC: begin
					if (k_q == 2'd3) begin
						state_q <= S_OUT_C;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= S_R_MLO;
					end
				end
				S_OUT_C: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			pos_q      <= pos;
			vx_q       <= vel_x;
			vy_q       <= vel_y;
			vz_q       <= vel_z;
			w_q        <= weight;
			rep_mode_q <= (func == FUNC_REPORT);
		end
		case (state_q)
			S_CELL: begin
				ip_q   <= ip_c;
				frac_q <= frac_c;
			end
			S_RD1:  sum_q    <= prod_q;
			S_EZ:   ez_q     <= ez_sum[47:16];
			S_VZ:   vzn_q    <= vzn_c;
			S_Z:    z_q      <= $signed({18'd0, pos_q}) + $signed({prod_q[63], prod_q[63:16]});
			S_V1:   v2_q     <= prod_q[63:0];
			S_V2:   v2_q     <= v2_q + prod_q[63:0];
			S_V3:   v2_q     <= v2_q + prod_q[63:0];
			S_E1:   elo_q    <= prod_q[62:32];
			S_EN:   energy_q <= (e_sum[63:31] != '0) ? MAX31 : e_sum[30:0];
			S_SQRT: begin
				if (sq_stat.done && (sq_root == '0)) begin
					cos_q <= '0;
				end
			end
			S_DIV: begin
				if (dv_stat.done) begin
					cos_q <= dv_quo;
				end
			end
			S_WE:    fadd_q   <= prod_q[47:16];
			S_WE2:   we_q     <= prod_q[61:16];
			S_WE4:   lo_q     <= prod_q[48:0];
			S_EADD:  eadd_q   <= {prod_q[31:0], 16'd0} + {15'd0, lo_q[48:16]};
			S_R_MLO: acc_hi_q <= accv[47:24];
			S_R_MHI: lop_q    <= prod_q[54:0];
			S_R_ACC: rep_q[k_q] <= (rep_sum[63:47] != '0) ? MAX47 : rep_sum[46:0];
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			kind_q       <= rep_mode_q ? KIND_REPORT : KIND_PARTICLE;
			pos_new_q    <= rep_mode_q ? '0 : z_q[30:0];
			vx_out_q     <= rep_mode_q ? '0 : vx_q;
			vy_out_q     <= rep_mode_q ? '0 : vy_q;
			vzn_out_q    <= rep_mode_q ? '0 : vzn_q;
			energy_out_q <= rep_mode_q ? '0 : energy_q;
			w_out_q      <= rep_mode_q ? '0 : w_q;
			fl_q         <= rep_mode_q ? rep_q[0] : '0;
			fh_q         <= rep_mode_q ? rep_q[1] : '0;
			efl_q        <= rep_mode_q ? rep_q[2] : '0;
			efh_q        <= rep_mode_q ? rep_q[3] : '0;
		end
	end

	assign res_valid  = res_valid_q;
	assign kind       = kind_q;
	assign pos_new    = pos_new_q;
	assign vel_x_out  = vx_out_q;
	assign vel_y_out  = vy_out_q;
	assign vel_z_new  = vzn_out_q;
	assign energy     = energy_out_q;
	assign weight_out = w_out_q;
	assign flux_low   = fl_q;
	assign flux_high  = fh_q;
	assign eflux_low  = efl_q;
	assign eflux_high = efh_q;

`ifndef ASSERT_OFF
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(sq_stat.busy && dv_stat.busy))
		else $error("Square root and divider are busy at the same time.");

	a_cos_range: assert property (@(posedge clk) disable iff (!arst_n)
		dv_stat.done |-> (dv_quo <= 17'h10000))
		else $error("Direction cosine exceeds one.");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sq_stat.done |-> (({32'd0, sq_root} * {32'd0, sq_root}) <= v2_q))
		else $error("Square root result is too large.");
`endif

endmodule

// File: bench/pic_1d_particle_push_tb.sv
// Self-checking testbench for the 1D particle push: directed and randomized items checked against a built-in predictor.
`timescale 1ns / 100ps

module pic_1d_particle_push_tb;
	import pp_pkg::*;

	typedef struct packed {
		logic [1:0]  fn;
		logic [9:0]  idx;
		logic [31:0] fval;
		logic [30:0] pos;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic [30:0] wt;
	} push_item_t;

	typedef struct packed {
		logic        kind;
		logic [30:0] pos_new;
		logic [31:0] vel_x_out;
		logic [31:0] vel_y_out;
		logic [31:0] vel_z_new;
		logic [30:0] energy;
		logic [30:0] weight_out;
		logic [46:0] flux_low;
		logic [46:0] flux_high;
		logic [46:0] eflux_low;
		logic [46:0] eflux_high;
	} particle_rec_t;

	localparam int NPTS = GRID_POINTS_DEF;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	logic [1:0]  func = '0;
	logic [9:0]  field_index = '0;
	logic [31:0] field_value = '0;
	logic [30:0] pos = '0;
	logic [31:0] vel_x = '0;
	logic [31:0] vel_y = '0;
	logic [31:0] vel_z = '0;
	logic [30:0] weight = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	particle_rec_t got;

	pic_1d_particle_push DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item_valid(item_valid), .item_ready(item_ready),
		.func(func), .field_index(field_index), .field_value(field_value), .pos(pos),
		.vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z), .weight(weight),
		.res_valid(res_valid), .res_ready(res_ready),
		.kind(got.kind), .pos_new(got.pos_new), .vel_x_out(got.vel_x_out),
		.vel_y_out(got.vel_y_out), .vel_z_new(got.vel_z_new), .energy(got.energy),
		.weight_out(got.weight_out), .flux_low(got.flux_low), .flux_high(got.flux_high),
		.eflux_low(got.eflux_low), .eflux_high(got.eflux_high)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state.
	logic [31:0] field_mem [NPTS];
	bit          field_loaded [NPTS];
	logic [47:0] acc_fl, acc_fh, acc_el, acc_eh;
	logic [31:0] m_accel;
	logic [30:0] m_tstep, m_inv_cell, m_domain, m_escale, m_fscale, m_efscale;

	push_item_t    item_backlog[$];
	particle_rec_t pending_records[$];
	int send_idle = 0;
	int recv_stall = 0;
	int errors = 0;
	int n_push = 0, n_survived = 0, n_reports = 0, n_beats_out = 0;
	int stall_hold = 0;
	bit pressure_go = 0, pressure_done = 0;

	function automatic longint unsigned scale_sat(input longint unsigned a, input longint unsigned b,
			input int s, input longint unsigned mx);
		logic [127:0] p;
		p = ({64'd0, a} * {64'd0, b}) >> s;
		return (p > mx) ? mx : p[63:0];
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint unsigned grid_cell(input logic [30:0] p);
		longint unsigned c;
		c = (longint'(p) * longint'(m_inv_cell)) >> 16;
		if (c > (longint'(NPTS - 1) << 16))
			c = longint'(NPTS - 1) << 16;
		return c;
	endfunction

	function automatic int grid_point(input logic [30:0] p);
		longint unsigned ip;
		ip = grid_cell(p) >> 16;
		if (ip > NPTS - 2)
			ip = NPTS - 2;
		return int'(ip);
	endfunction

	function automatic logic [47:0] acc_add(input logic [47:0] a, input longint unsigned x);
		longint unsigned s;
		s = longint'(a) + x;
		return (s > longint'(MAX48)) ? MAX48 : s[47:0];
	endfunction

	function automatic bit advance_particle(input push_item_t it, output particle_rec_t r);
		longint unsigned cell_pos, frac, v2, en, sp, avz, cosv, fadd, eadd;
		longint f0, f1, ez, vzn, z, vxs, vys;
		int ip;
		r = '0;
		if (it.fn == FUNC_LOAD) begin
			field_mem[it.idx] = it.fval;
			field_loaded[it.idx] = 1;
			return 0;
		end
		if (it.fn == FUNC_REPORT) begin
			r.kind = KIND_REPORT;
			r.flux_low = scale_sat(acc_fl, m_fscale, 16, MAX47);
			r.flux_high = scale_sat(acc_fh, m_fscale, 16, MAX47);
			r.eflux_low = scale_sat(acc_el, m_efscale, 16, MAX47);
			r.eflux_high = scale_sat(acc_eh, m_efscale, 16, MAX47);
			acc_fl = '0; acc_fh = '0; acc_el = '0; acc_eh = '0;
			return 1;
		end
		if (it.fn != FUNC_PUSH)
			return 0;
		cell_pos = grid_cell(it.pos);
		ip = grid_point(it.pos);
		frac = cell_pos - (longint'(ip) << 16);
		f0 = $signed(field_mem[ip]);
		f1 = $signed(field_mem[ip + 1]);
		ez = (f0 * longint'(65536 - frac) + f1 * longint'(frac)) >>> 16;
		vzn = longint'($signed(it.vz)) + ((longint'($signed(m_accel)) * ez) >>> 16);
		if (vzn > 64'sd2147483647)
			vzn = 64'sd2147483647;
		if (vzn < -64'sd2147483648)
			vzn = -64'sd2147483648;
		z = longint'(it.pos) + ((vzn * longint'(m_tstep)) >>> 16);
		vxs = $signed(it.vx);
		vys = $signed(it.vy);
		v2 = longint'(vxs * vxs) + longint'(vys * vys) + longint'(vzn * vzn);
		en = scale_sat(m_escale, v2, 32, MAX31);
		if (z > 0 && z < longint'(m_domain)) begin
			r.kind = KIND_PARTICLE;
			r.pos_new = z[30:0];
			r.vel_x_out = it.vx;
			r.vel_y_out = it.vy;
			r.vel_z_new = vzn[31:0];
			r.energy = en[30:0];
			r.weight_out = it.wt;
			return 1;
		end
		sp = int_sqrt(v2);
		avz = (vzn < 0) ? -vzn : vzn;
		cosv = (sp == 0) ? 0 : (avz << 16) / sp;
		fadd = (longint'(it.wt) * cosv) >> 16;
		eadd = (((longint'(it.wt) * en) >> 16) * cosv) >> 16;
		if (z <= 0) begin
			acc_fl = acc_add(acc_fl, fadd);
			acc_el = acc_add(acc_el, eadd);
		end else begin
			acc_fh = acc_add(acc_fh, fadd);
			acc_eh = acc_add(acc_eh, eadd);
		end
		return 0;
	endfunction

	function automatic void queue_item(input push_item_t it);
		particle_rec_t r;
		push_item_t ld;
		int ip;
		if (it.fn == FUNC_PUSH) begin
			ip = grid_point(it.pos);
			for (int k = ip; k <= ip + 1; k++) begin
				if (!field_loaded[k]) begin
					ld = '0;
					ld.fn = FUNC_LOAD;
					ld.idx = k[9:0];
					ld.fval = $urandom();
					queue_item(ld);
				end
			end
			n_push++;
		end
		if (advance_particle(it, r)) begin
			pending_records.push_back(r);
			if (r.kind == KIND_PARTICLE)
				n_survived++;
			else
				n_reports++;
		end
		item_backlog.push_back(it);
	endfunction

	function automatic push_item_t make_push(input logic [30:0] p, input logic [31:0] x,
			input logic [31:0] y, input logic [31:0] zv, input logic [30:0] w);
		push_item_t it;
		it = '0;
		it.fn = FUNC_PUSH;
		it.pos = p; it.vx = x; it.vy = y; it.vz = zv; it.wt = w;
		return it;
	endfunction

	function automatic push_item_t make_op(input logic [1:0] f);
		push_item_t it;
		it = '0;
		it.fn = f;
		return it;
	endfunction

	function automatic logic [31:0] rand_vel();
		int sh;
		if ($urandom_range(0, 3) == 0)
			return $urandom();
		sh = $urandom_range(4, 24);
		return 32'($signed($urandom_range(0, 2 ** sh)) - (2 ** (sh - 1)));
	endfunction

	function automatic push_item_t rand_item();
		push_item_t it;
		int sel;
		logic [30:0] p;
		sel = $urandom_range(0, 99);
		it = '0;
		if (sel < 14) begin
			it.fn = FUNC_LOAD;
			it.idx = 10'($urandom());
			it.fval = $urandom();
		end else if (sel < 92) begin
			if ($urandom_range(0, 4) != 0)
				p = 31'($urandom_range(0, m_domain));
			else
				p = 31'($urandom());
			it = make_push(p, rand_vel(), rand_vel(), rand_vel(),
				($urandom_range(0, 1) != 0) ? 31'($urandom()) : 31'($urandom_range(0, 1 << 20)));
		end else if (sel < 97) begin
			it.fn = FUNC_REPORT;
		end else begin
			it = make_op(FUNC_UNUSED);
			it.pos = 31'($urandom());
			it.vz = $urandom();
		end
		return it;
	endfunction

	task automatic write_reg(input reg_t ri, input logic [31:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ri)
			REG_ACCEL:      m_accel = d;
			REG_TIME_STEP:  m_tstep = d[30:0];
			REG_INV_CELL:   m_inv_cell = d[30:0];
			REG_DOMAIN_LEN: m_domain = d[30:0];
			REG_ENERGY_SCL: m_escale = d[30:0];
			REG_FLUX_SCL:   m_fscale = d[30:0];
			REG_EFLUX_SCL:  m_efscale = d[30:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] a, input logic [31:0] ts, input logic [31:0] ic,
			input logic [31:0] dl, input logic [31:0] es, input logic [31:0] fs,
			input logic [31:0] efs);
		write_reg(REG_ACCEL, a);
		write_reg(REG_TIME_STEP, ts);
		write_reg(REG_INV_CELL, ic);
		write_reg(REG_DOMAIN_LEN, dl);
		write_reg(REG_ENERGY_SCL, es);
		write_reg(REG_FLUX_SCL, fs);
		write_reg(REG_EFLUX_SCL, efs);
	endtask

	task automatic drain();
		while (item_backlog.size() != 0 || item_valid || pending_records.size() != 0)
			@(posedge clk);
		// An absorbed particle gives no beat but keeps the block busy for a while.
		repeat (120) @(posedge clk);
	endtask

	// Item driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				push_item_t it;
				it = item_backlog.pop_front();
				item_valid <= 1'b1;
				func <= it.fn;
				field_index <= it.idx;
				field_value <= it.fval;
				pos <= it.pos;
				vel_x <= it.vx;
				vel_y <= it.vy;
				vel_z <= it.vz;
				weight <= it.wt;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Long receiver hold-off, counted in its own process.
	always @(posedge clk) begin
		if (pressure_go && !pressure_done) begin
			stall_hold <= 400;
			pressure_done <= 1;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end
	end

	// Result monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ready <= 1'b0;
		end else begin
			res_ready <= (stall_hold == 0) && ($urandom_range(0, 99) >= recv_stall);
			if (res_valid && res_ready) begin
				n_beats_out++;
				if (pending_records.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result beat: %p", got);
				end else begin
					particle_rec_t e;
					e = pending_records.pop_front();
					if (e !== got) begin
						errors++;
						if (errors <= 10)
							$display("mismatch:\n  expected %p\n  actual   %p", e, got);
					end
				end
			end
		end
	end

	initial begin
		#5000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		logic [31:0] vmin;
		vmin = 32'h8000_0000;
		acc_fl = '0; acc_fh = '0; acc_el = '0; acc_eh = '0;
		m_accel = ACCEL_RST; m_tstep = TIME_STEP_RST; m_inv_cell = INV_CELL_RST;
		m_domain = DOMAIN_LEN_RST; m_escale = ENERGY_SCL_RST;
		m_fscale = FLUX_SCL_RST; m_efscale = EFLUX_SCL_RST;
		for (int k = 0; k < NPTS; k++)
			field_loaded[k] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with field extremes, both walls and saturation.
		write_all(32'd65536, 32'd65536, 32'd1048576, 32'd2097152, 32'd32768, 32'd65536, 32'd65536);
		begin
			push_item_t it;
			it = make_op(FUNC_LOAD); it.idx = 10'd0; it.fval = 32'h7fff_ffff; queue_item(it);
			it = make_op(FUNC_LOAD); it.idx = 10'd1; it.fval = 32'h8000_0000; queue_item(it);
			it = make_op(FUNC_LOAD); it.idx = 10'd1023; it.fval = 32'hffff_ffff; queue_item(it);
			it = make_op(FUNC_LOAD); it.idx = 10'd1022; it.fval = 32'd65536; queue_item(it);
		end
		queue_item(make_push(31'h10000, 32'd100, -32'sd100, 32'd4096, 31'd65536));
		queue_item(make_push(31'd0, 32'd0, 32'd0, 32'd0, 31'h7fff_ffff));
		queue_item(make_push(31'h7fff_ffff, 32'd65536, 32'd0, 32'd0, 31'd65536));
		queue_item(make_push(31'd65536, 32'd0, 32'd0, -32'sd33554432, 31'd131072));
		queue_item(make_push(31'd65536, vmin, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff));
		queue_item(make_op(FUNC_REPORT));
		queue_item(make_op(FUNC_UNUSED));
		repeat (8)
			queue_item(make_push(31'h7fff_ffff, vmin, vmin, vmin, 31'h7fff_ffff));
		queue_item(make_op(FUNC_REPORT));
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				2: write_all(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0,
					32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
				4: write_all(32'h7fff_ffff, 32'd0, 32'd0, 32'h7fff_ffff, 32'd0, 32'd0, 32'd0);
				default: write_all(32'($signed($urandom_range(0, 1 << 15)) - (1 << 14)),
					$urandom_range(1 << 10, 1 << 16), $urandom_range(1 << 12, 1 << 18),
					$urandom_range(1 << 16, 1 << 24), $urandom_range(0, 1 << 20),
					$urandom_range(0, 1 << 18), $urandom_range(0, 1 << 18));
			endcase
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 70; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 70; end
				default: begin send_idle = 7; recv_stall = 7; end
			endcase
			if (ph == 0)
				pressure_go = 1;
			for (int n = 0; n < 210; n++)
				queue_item(rand_item());
			queue_item(make_op(FUNC_REPORT));
			drain();
		end

		errors += pending_records.size();
		$display("Covered %0d particle pushes (%0d survived) and %0d flux reports,", n_push,
			n_survived, n_reports);
		$display("%0d result beats over seven register settings and four idle mixes.", n_beats_out);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
